### hdl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/lphtu_pkg.sv
// types and constants of the linear probe hash table unit
`timescale 1ns / 1ps
package lphtu_pkg;
    localparam int KEY_W = 64;
    localparam int VAL_W = 32;
    localparam int CAP_W = 9;
    localparam int CNT_W = 9;
    localparam int SI_W  = 8;
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_SEARCH = 3'd1,
        OP_ERASE  = 3'd2,
        OP_FIRST  = 3'd3,
        OP_NEXT   = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOTF   = 2'd1,
        ST_FULL   = 2'd2,
        ST_NOMORE = 2'd3
    } t_status;
endpackage

### hdl/linear_probe_hash_table_unit.sv
// top level of the linear probe hash table unit
//
//  channel  | direction | handshake               | word
//  command  | in        | start & !busy           | op, key, value
//  result   | out       | o_valid, one cycle      | hit, entry_key, entry_value,
//           |           |                         | slot_index, status, count_now
//  config   | in        | i_cfg_valid & o_cfg_ready | table_capacity
//
// after reset a clearing pass writes every slot of the flag memory, busy high
// insert, search, erase: the key is hashed up to KEY_CHARS characters, reduced modulo
//   the capacity, then probed slot by slot from its home slot
// first, next: slots are read one by one until a live entry or the end of the
//   capacity; an unknown op goes straight to the result
// the result strobe cannot be held off; the next command is taken with it
`timescale 1ns / 1ps
`include "assert_macros.svh"
module linear_probe_hash_table_unit #(
    parameter int SLOTS     = 256,
    parameter int KEY_CHARS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lphtu_pkg::OP_W-1:0]  i_op,
    input  logic [lphtu_pkg::KEY_W-1:0] i_key,
    input  logic [lphtu_pkg::VAL_W-1:0] i_value,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic [lphtu_pkg::KEY_W-1:0] o_entry_key,
    output logic [lphtu_pkg::VAL_W-1:0] o_entry_value,
    output logic [lphtu_pkg::SI_W-1:0]  o_slot_index,
    output logic [lphtu_pkg::ST_W-1:0]  o_status,
    output logic [lphtu_pkg::CNT_W-1:0] o_count_now,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lphtu_pkg::CAP_W-1:0] i_cfg_data
);
    import lphtu_pkg::*;

    localparam int IW   = $clog2(SLOTS);
    localparam int LW   = ((IW + 1) > (CAP_W + 1)) ? (IW + 1) : (CAP_W + 1);
    localparam int CI_W = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam int RW   = CAP_W + 1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_HASH, S_MOD, S_PRD, S_PCHK, S_SRD, S_SCHK, S_FIN
    } t_state;

    t_state             r_state;
    logic [IW-1:0]      r_idx;
    logic [LW-1:0]      r_pos;
    logic [LW-1:0]      r_n;
    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_val;
    logic [KEY_W-1:0]   r_h;
    logic [RW-1:0]      r_rem;
    logic [3:0]         r_mc;
    logic [CI_W-1:0]    r_ci;
    logic               r_m_ok, r_t_ok, r_e_ok;
    logic [IW-1:0]      r_m, r_t, r_e;
    logic [KEY_W-1:0]   r_ek;
    logic [VAL_W-1:0]   r_ev;
    logic [CAP_W-1:0]   r_cap;
    logic [CNT_W-1:0]   r_count;
    logic [LW-1:0]      r_cur_next;
    logic               r_valid, r_hit;
    logic [KEY_W-1:0]   r_o_key;
    logic [VAL_W-1:0]   r_o_val;
    logic [SI_W-1:0]    r_si;
    logic [ST_W-1:0]    r_st;

    // memories and their registered read data
    logic [1:0]         mem_flag [SLOTS];
    logic [KEY_W-1:0]   mem_key  [SLOTS];
    logic [VAL_W-1:0]   mem_val  [SLOTS];
    logic [1:0]         r_q_flag;
    logic [KEY_W-1:0]   r_q_key;
    logic [VAL_W-1:0]   r_q_val;

    logic [LW-1:0]      w_cap;
    logic [KEY_W-1:0]   w_canon;
    logic [7:0]         w_byte, w_lc;
    logic [RW-1:0]      w_rem_next;
    logic [IW-1:0]      w_raddr;
    logic               w_rd_en;
    logic               w_sel_ok;
    logic [IW-1:0]      w_sel;
    logic               w_flag_we, w_kv_we, w_val_we;
    logic [IW-1:0]      w_waddr;
    logic [1:0]         w_flag_wd;
    logic               w_accept;

    assign w_accept    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // effective capacity, clamped to one and SLOTS
    always_comb begin
        if (r_cap == '0) begin
            w_cap = LW'(1);
        end else if (LW'(r_cap) > LW'(SLOTS)) begin
            w_cap = LW'(SLOTS);
        end else begin
            w_cap = LW'(r_cap);
        end
    end

    // key masked after its terminator and beyond KEY_CHARS
    always_comb begin
        logic keep;
        keep    = 1'b1;
        w_canon = '0;
        for (int j = 0; j < 8; j++) begin
            keep = keep && (j < KEY_CHARS) && (i_key[8*j +: 8] != 8'h00);
            if (keep) begin
                w_canon[8*j +: 8] = i_key[8*j +: 8];
            end
        end
    end

    // current character, lowercased
    assign w_byte = r_key[8*r_ci +: 8];
    assign w_lc   = (w_byte >= 8'h41 && w_byte <= 8'h5A) ? (w_byte + 8'd32) : w_byte;

    // four restoring modulo steps per cycle
    always_comb begin
        logic [RW-1:0] rem;
        rem = r_rem;
        for (int b = 0; b < 4; b++) begin
            rem = {rem[RW-2:0], r_h[KEY_W-1-b]};
            if (rem >= RW'(w_cap)) begin
                rem = rem - RW'(w_cap);
            end
        end
        w_rem_next = rem;
    end

    // slot chosen by the finishing operation
    always_comb begin
        w_sel_ok = 1'b0;
        w_sel    = r_m;
        if (r_m_ok) begin
            w_sel_ok = 1'b1;
        end else if (r_op == OP_INSERT && r_t_ok) begin
            w_sel_ok = 1'b1;
            w_sel    = r_t;
        end else if (r_op == OP_INSERT && r_e_ok) begin
            w_sel_ok = 1'b1;
            w_sel    = r_e;
        end
    end

    // memory port control
    always_comb begin
        w_rd_en   = (r_state == S_PRD) || (r_state == S_SRD);
        w_raddr   = (r_state == S_SRD) ? IW'(r_pos) : r_idx;
        w_flag_we = 1'b0;
        w_kv_we   = 1'b0;
        w_val_we  = 1'b0;
        w_waddr   = w_sel;
        w_flag_wd = 2'b00;
        if (r_state == S_CLR) begin
            w_flag_we = 1'b1;
            w_waddr   = r_idx;
        end else if (r_state == S_FIN && w_sel_ok) begin
            if (r_op == OP_INSERT) begin
                w_val_we = 1'b1;
                if (!r_m_ok) begin
                    w_flag_we = 1'b1;
                    w_kv_we   = 1'b1;
                    w_flag_wd = 2'b11;
                end
            end else if (r_op == OP_ERASE) begin
                w_flag_we = 1'b1;
                w_flag_wd = 2'b10;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_flag_we) begin
            mem_flag[w_waddr] <= w_flag_wd;
        end
        if (w_rd_en) begin
            r_q_flag <= mem_flag[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_kv_we) begin
            mem_key[w_waddr] <= r_key;
        end
        if (w_rd_en) begin
            r_q_key <= mem_key[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_val_we) begin
            mem_val[w_waddr] <= r_val;
        end
        if (w_rd_en) begin
            r_q_val <= mem_val[w_raddr];
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // sequencer and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_idx      <= '0;
            r_count    <= '0;
            r_cur_next <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    if (r_idx == IW'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_idx <= r_idx + IW'(1);
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op   <= i_op;
                        r_key  <= w_canon;
                        r_val  <= i_value;
                        r_h    <= '0;
                        r_ci   <= '0;
                        r_rem  <= '0;
                        r_mc   <= '0;
                        r_m_ok <= 1'b0;
                        r_t_ok <= 1'b0;
                        r_e_ok <= 1'b0;
                        r_n    <= '0;
                        r_pos  <= (i_op == OP_NEXT) ? r_cur_next : '0;
                        if (i_op == OP_INSERT || i_op == OP_SEARCH || i_op == OP_ERASE) begin
                            r_state <= S_HASH;
                        end else if (i_op == OP_FIRST || i_op == OP_NEXT) begin
                            r_state <= S_SRD;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_HASH: begin
                    if (w_byte == 8'h00) begin
                        r_state <= S_MOD;
                    end else begin
                        r_h <= (r_h << 5) + r_h + KEY_W'(w_lc);
                        if (r_ci == CI_W'(KEY_CHARS - 1)) begin
                            r_state <= S_MOD;
                        end else begin
                            r_ci <= r_ci + CI_W'(1);
                        end
                    end
                end
                S_MOD: begin
                    r_rem <= w_rem_next;
                    r_h   <= r_h << 4;
                    r_mc  <= r_mc + 4'd1;
                    if (r_mc == 4'd15) begin
                        r_idx   <= IW'(w_rem_next);
                        r_state <= S_PRD;
                    end
                end
                S_PRD: begin
                    r_state <= S_PCHK;
                end
                S_PCHK: begin
                    if (!r_q_flag[1]) begin
                        r_e_ok  <= 1'b1;
                        r_e     <= r_idx;
                        r_state <= S_FIN;
                    end else if (r_q_flag[0] && r_q_key == r_key) begin
                        r_m_ok  <= 1'b1;
                        r_m     <= r_idx;
                        r_ek    <= r_q_key;
                        r_ev    <= r_q_val;
                        r_state <= S_FIN;
                    end else begin
                        if (!r_q_flag[0] && !r_t_ok) begin
                            r_t_ok <= 1'b1;
                            r_t    <= r_idx;
                        end
                        if (r_n == w_cap - LW'(1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_n     <= r_n + LW'(1);
                            r_idx   <= (LW'(r_idx) + LW'(1) == w_cap) ? '0 : r_idx + IW'(1);
                            r_state <= S_PRD;
                        end
                    end
                end
                S_SRD: begin
                    r_state <= (r_pos >= w_cap) ? S_FIN : S_SCHK;
                end
                S_SCHK: begin
                    if (r_q_flag[0]) begin
                        r_m_ok  <= 1'b1;
                        r_m     <= IW'(r_pos);
                        r_ek    <= r_q_key;
                        r_ev    <= r_q_val;
                        r_state <= S_FIN;
                    end else begin
                        r_pos   <= r_pos + LW'(1);
                        r_state <= S_SRD;
                    end
                end
                S_FIN: begin
                    r_valid <= 1'b1;
                    r_hit   <= 1'b0;
                    r_o_key <= '0;
                    r_o_val <= '0;
                    r_si    <= '0;
                    r_st    <= ST_NOTF;
                    r_state <= S_IDLE;
                    case (r_op)
                        OP_INSERT: begin
                            if (w_sel_ok) begin
                                r_hit      <= 1'b1;
                                r_o_key    <= r_key;
                                r_o_val    <= r_val;
                                r_si       <= SI_W'(w_sel);
                                r_st       <= ST_OK;
                                r_cur_next <= LW'(w_sel) + LW'(1);
                                if (!r_m_ok) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end else begin
                                r_st <= ST_FULL;
                            end
                        end
                        OP_SEARCH, OP_ERASE: begin
                            if (r_m_ok) begin
                                r_hit      <= 1'b1;
                                r_o_key    <= r_ek;
                                r_o_val    <= r_ev;
                                r_si       <= SI_W'(r_m);
                                r_st       <= ST_OK;
                                r_cur_next <= LW'(r_m) + LW'(1);
                                if (r_op == OP_ERASE) begin
                                    r_count <= r_count - CNT_W'(1);
                                end
                            end else if (r_op == OP_SEARCH && r_e_ok) begin
                                r_si       <= SI_W'(r_e);
                                r_cur_next <= LW'(r_e) + LW'(1);
                            end
                        end
                        OP_FIRST, OP_NEXT: begin
                            if (r_m_ok) begin
                                r_hit      <= 1'b1;
                                r_o_key    <= r_ek;
                                r_o_val    <= r_ev;
                                r_si       <= SI_W'(r_m);
                                r_st       <= ST_OK;
                                r_cur_next <= LW'(r_m) + LW'(1);
                            end else begin
                                r_st <= ST_NOMORE;
                            end
                        end
                        default: begin
                            r_st <= ST_NOTF;
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign o_valid       = r_valid;
    assign o_hit         = r_hit;
    assign o_entry_key   = r_o_key;
    assign o_entry_value = r_o_val;
    assign o_slot_index  = r_si;
    assign o_status      = r_st;
    assign o_count_now   = r_count;

    // checks
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_SAME(a_result_after_work, i_clk, i_rst_n, o_valid, $past(busy))
    `ASSERT_SAME(a_hit_status, i_clk, i_rst_n, o_valid, o_hit == (o_status == ST_OK))
endmodule

### verif/testbench.sv
// self-checking testbench of the linear probe hash table unit
`timescale 1ns / 1ps
module testbench;
    import lphtu_pkg::*;

    localparam int NUM_SLOTS  = 256;
    localparam int WATCH_MAX  = 20000;
    localparam int POOL_SIZE  = 40;
    localparam int PHASE_ITEMS = 250;

    // one result word
    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] ekey;
        logic [VAL_W-1:0] evalue;
        logic [SI_W-1:0]  slot;
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_entry_word;

    // directed row: command plus optional typed-in answer
    typedef struct {
        t_op         op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        bit          typed;
        t_entry_word answer;
    } t_cmd_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [OP_W-1:0]  i_op;
    logic [KEY_W-1:0] i_key;
    logic [VAL_W-1:0] i_value;
    logic             o_valid;
    logic             o_hit;
    logic [KEY_W-1:0] o_entry_key;
    logic [VAL_W-1:0] o_entry_value;
    logic [SI_W-1:0]  o_slot_index;
    logic [ST_W-1:0]  o_status;
    logic [CNT_W-1:0] o_count_now;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data;

    linear_probe_hash_table_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_key(i_key), .i_value(i_value),
        .o_valid(o_valid), .o_hit(o_hit), .o_entry_key(o_entry_key),
        .o_entry_value(o_entry_value), .o_slot_index(o_slot_index),
        .o_status(o_status), .o_count_now(o_count_now),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // shadow of the table
    bit               shadow_used [NUM_SLOTS];
    bit               shadow_live [NUM_SLOTS];
    logic [KEY_W-1:0] shadow_key  [NUM_SLOTS];
    logic [VAL_W-1:0] shadow_value[NUM_SLOTS];
    int               shadow_count;
    int               shadow_cursor_next;
    int               shadow_capacity;

    t_entry_word      pending_words[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    bit               failed;
    int               watch_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // key up to the first zero byte
    function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (k[8*i +: 8] == 8'h00) break;
            r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

    function automatic int key_chars(logic [KEY_W-1:0] k);
        int n;
        n = 0;
        while (n < 8 && k[8*n +: 8] != 8'h00) n++;
        return n;
    endfunction

    // case-folded times-33 hash, reduced by the capacity
    function automatic int home_slot(logic [KEY_W-1:0] k, int cap);
        logic [63:0] h;
        logic [63:0] b;
        h = '0;
        for (int i = 0; i < 8; i++) begin
            b = {56'd0, k[8*i +: 8]};
            if (b == 0) break;
            if (b >= 64'h41 && b <= 64'h5A) b = b + 64'd32;
            h = h * 64'd33 + b;
        end
        return int'(h % 64'(cap));
    endfunction

    // linear probe: match, first tombstone, ending empty slot
    task automatic probe_chain(input logic [KEY_W-1:0] k, input int cap,
                               output int match, output int tomb, output int empty);
        int i;
        match = -1; tomb = -1; empty = -1;
        i = home_slot(k, cap);
        for (int n = 0; n < cap; n++) begin
            if (!shadow_used[i]) begin
                empty = i;
                return;
            end
            if (!shadow_live[i]) begin
                if (tomb < 0) tomb = i;
            end else if (shadow_key[i] == k) begin
                match = i;
                return;
            end
            i = (i + 1 == cap) ? 0 : i + 1;
        end
    endtask

    // work out the result word of one command and update the shadow
    task automatic table_predict(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] raw_key,
                                 input logic [VAL_W-1:0] v, output t_entry_word w);
        logic [KEY_W-1:0] k;
        int cap, m, t, e, s;
        k = trim_key(raw_key);
        cap = shadow_capacity;
        if (cap == 0) cap = 1;
        if (cap > NUM_SLOTS) cap = NUM_SLOTS;
        w = '0;
        w.status = ST_NOTF;
        case (op)
            OP_INSERT: begin
                probe_chain(k, cap, m, t, e);
                s = (m >= 0) ? m : ((t >= 0) ? t : e);
                if (s >= 0) begin
                    if (m < 0) begin
                        shadow_used[s] = 1'b1;
                        shadow_live[s] = 1'b1;
                        shadow_key[s] = k;
                        shadow_count++;
                    end
                    shadow_value[s] = v;
                    shadow_cursor_next = s + 1;
                    w.hit = 1'b1; w.ekey = k; w.evalue = v;
                    w.status = ST_OK; w.slot = SI_W'(s);
                end else begin
                    w.status = ST_FULL;
                end
            end
            OP_SEARCH, OP_ERASE: begin
                probe_chain(k, cap, m, t, e);
                if (m >= 0) begin
                    w.hit = 1'b1; w.ekey = shadow_key[m]; w.evalue = shadow_value[m];
                    w.status = ST_OK; w.slot = SI_W'(m);
                    shadow_cursor_next = m + 1;
                    if (op == OP_ERASE) begin
                        shadow_live[m] = 1'b0;
                        shadow_count--;
                    end
                end else if (op == OP_SEARCH && e >= 0) begin
                    w.slot = SI_W'(e);
                    shadow_cursor_next = e + 1;
                end
            end
            OP_FIRST, OP_NEXT: begin
                s = -1;
                for (int i = (op == OP_FIRST) ? 0 : shadow_cursor_next; i < cap; i++) begin
                    if (shadow_live[i]) begin
                        s = i;
                        break;
                    end
                end
                if (s >= 0) begin
                    w.hit = 1'b1; w.ekey = shadow_key[s]; w.evalue = shadow_value[s];
                    w.status = ST_OK; w.slot = SI_W'(s);
                    shadow_cursor_next = s + 1;
                end else begin
                    w.status = ST_NOMORE;
                end
            end
            default: ;
        endcase
        w.count = CNT_W'(shadow_count);
    endtask

    // issue one command, holding start until it is taken
    task automatic issue_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v, input int idle_pct,
                             input bit typed, input t_entry_word answer);
        t_entry_word w;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= op;
        i_key <= k;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        table_predict(op, k, v, w);
        pending_words.push_back(typed ? answer : w);
    endtask

    // write the capacity register once the block is quiet
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        start <= 1'b0;
        while (pending_words.size() != 0 || busy) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_capacity = int'(cap);
    endtask

    // random pool key: mixed case, digits, high bytes, any length
    function automatic logic [KEY_W-1:0] make_pool_key();
        logic [KEY_W-1:0] k;
        int len;
        k = '0;
        len = $urandom_range(8);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(3))
                0: k[8*i +: 8] = 8'($urandom_range(8'h61, 8'h63));
                1: k[8*i +: 8] = 8'($urandom_range(8'h41, 8'h43));
                2: k[8*i +: 8] = 8'($urandom_range(8'h30, 8'h39));
                default: k[8*i +: 8] = 8'($urandom_range(8'h80, 8'hFF));
            endcase
        end
        return k;
    endfunction

    // random command key: mostly pool keys, some with junk past the terminator
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] junk;
        int n;
        if ($urandom_range(99) < 12) return {$urandom, $urandom};
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
        n = key_chars(k);
        if (n < 7 && $urandom_range(99) < 30) begin
            junk = {$urandom, $urandom};
            k = k | ((junk >> (8 * (n + 1))) << (8 * (n + 1)));
        end
        return k;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 35) return OP_INSERT;
        if (r < 60) return OP_SEARCH;
        if (r < 75) return OP_ERASE;
        if (r < 83) return OP_FIRST;
        if (r < 95) return OP_NEXT;
        return OP_W'($urandom_range(5, 7));
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_entry_word want;
        if (i_rst_n && o_valid) begin
            if (pending_words.size() == 0) begin
                $error("result word with nothing expected");
                failed <= 1'b1;
            end else begin
                want = pending_words.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0h, actual %0h", want.hit, o_hit);
                    failed <= 1'b1;
                end
                if (o_entry_key !== want.ekey) begin
                    $error("entry_key: expected %0h, actual %0h", want.ekey, o_entry_key);
                    failed <= 1'b1;
                end
                if (o_entry_value !== want.evalue) begin
                    $error("entry_value: expected %0h, actual %0h", want.evalue, o_entry_value);
                    failed <= 1'b1;
                end
                if (o_slot_index !== want.slot) begin
                    $error("slot_index: expected %0d, actual %0d", want.slot, o_slot_index);
                    failed <= 1'b1;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    failed <= 1'b1;
                end
                if (o_count_now !== want.count) begin
                    $error("count_now: expected %0d, actual %0d", want.count, o_count_now);
                    failed <= 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            watch_cycles <= 0;
        end else if (watch_cycles >= WATCH_MAX) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            watch_cycles <= watch_cycles + 1;
        end
    end

    // stimulus
    initial begin
        t_cmd_row    rows[$];
        t_entry_word none_word;
        logic [CAP_W-1:0] phase_caps[6];
        int idle_pct;

        failed = 1'b0;
        watch_cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_op = '0;
        i_key = '0;
        i_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            shadow_used[i] = 1'b0;
            shadow_live[i] = 1'b0;
            shadow_key[i] = '0;
            shadow_value[i] = '0;
        end
        shadow_count = 0;
        shadow_cursor_next = 0;
        shadow_capacity = int'(CAP_RESET);
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = make_pool_key();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed commands on the empty table first, answers typed in
        none_word = '0;
        none_word.status = ST_NOMORE;
        rows.push_back('{OP_FIRST, 64'h0, 32'h0, 1'b1, none_word});
        rows.push_back('{OP_NEXT, 64'h0, 32'h0, 1'b1, none_word});
        none_word.status = ST_NOTF;
        rows.push_back('{OP_ERASE, 64'h78, 32'h0, 1'b1, none_word});
        rows.push_back('{t_op'(3'd5), 64'h61, 32'h1, 1'b1, none_word});
        rows.push_back('{t_op'(3'd6), 64'h0, 32'h0, 1'b1, none_word});
        rows.push_back('{t_op'(3'd7), '1, '1, 1'b1, none_word});
        // insert, case variants, junk after terminator, replace, tombstones
        rows.push_back('{OP_INSERT, 64'h636261, 32'hFFFF_FFFF, 1'b0, '0});
        rows.push_back('{OP_INSERT, 64'h434241, 32'h0, 1'b0, '0});
        rows.push_back('{OP_SEARCH, 64'hFFFF_0000_0063_6261, 32'h0, 1'b0, '0});
        rows.push_back('{OP_INSERT, 64'h636261, 32'h1234_5678, 1'b0, '0});
        rows.push_back('{OP_ERASE, 64'h636261, 32'h0, 1'b0, '0});
        rows.push_back('{OP_SEARCH, 64'h434241, 32'h0, 1'b0, '0});
        rows.push_back('{OP_SEARCH, 64'h636261, 32'h0, 1'b0, '0});
        rows.push_back('{OP_INSERT, 64'h636261, 32'h8000_0001, 1'b0, '0});
        rows.push_back('{OP_INSERT, '1, 32'hA5A5_5A5A, 1'b0, '0});
        rows.push_back('{OP_INSERT, 64'h0, 32'h0000_0001, 1'b0, '0});
        rows.push_back('{OP_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 32'h7FFF_FFFF, 1'b0, '0});
        rows.push_back('{OP_SEARCH, 64'h7A7A_7A7A_7A7A_7A7A, 32'h0, 1'b0, '0});
        rows.push_back('{OP_FIRST, 64'h0, 32'h0, 1'b0, '0});
        rows.push_back('{OP_NEXT, 64'h0, 32'h0, 1'b0, '0});
        rows.push_back('{OP_NEXT, 64'h0, 32'h0, 1'b0, '0});
        rows.push_back('{OP_ERASE, '1, 32'h0, 1'b0, '0});
        rows.push_back('{OP_NEXT, 64'h0, 32'h0, 1'b0, '0});
        foreach (rows[i])
            issue_cmd(rows[i].op, rows[i].key, rows[i].value, 0, rows[i].typed, rows[i].answer);

        // random phases over several capacities, extremes and out of range too
        phase_caps = '{9'd8, 9'd1, 9'd0, 9'd511, 9'd300, 9'd256};
        for (int p = 0; p < 6; p++) begin
            write_capacity(phase_caps[p]);
            idle_pct = (p < 2) ? 6 : ((p < 4) ? 79 : 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue_cmd(pick_op(), pick_key(), $urandom, idle_pct, 1'b0, '0);
        end
        write_capacity(9'd37);
        for (int n = 0; n < 60; n++)
            issue_cmd(pick_op(), pick_key(), $urandom, 0, 1'b0, '0);
        start <= 1'b0;

        // drain
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
